// File: design/sti_pkg.sv
// Package with widths, payload types and helper functions of the segment/triangle block.
package sti_pkg;

  localparam int CoordWidth = 16;
  localparam int DifWidth   = CoordWidth + 1;
  localparam int CrsWidth   = 2 * DifWidth + 1;
  localparam int PrdWidth   = DifWidth + CrsWidth;
  localparam int SumWidth   = PrdWidth + 2;
  localparam int NumWidth   = SumWidth + DifWidth;
  localparam int QuoWidth   = DifWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DifWidth-1:0]   dif_t;
  typedef logic signed [CrsWidth-1:0]   crs_t;
  typedef logic signed [PrdWidth-1:0]   prd_t;
  typedef logic signed [SumWidth-1:0]   sum_t;

  typedef struct packed {
    coord_t                      start_x;
    coord_t                      start_y;
    coord_t                      start_z;
    coord_t                      end_x;
    coord_t                      end_y;
    coord_t                      end_z;
    logic [3*CoordWidth-1:0]     vertex_a;
    logic [3*CoordWidth-1:0]     vertex_b;
    logic [3*CoordWidth-1:0]     vertex_c;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } out_t;

  function automatic dif_t sub_ext(coord_t a, coord_t b);
    dif_t ea;
    dif_t eb;
    ea = dif_t'(a);
    eb = dif_t'(b);
    return ea - eb;
  endfunction

  function automatic crs_t cross_el(dif_t a1, dif_t b2, dif_t a2, dif_t b1);
    logic signed [2*DifWidth-1:0] p0;
    logic signed [2*DifWidth-1:0] p1;
    p0 = a1 * b2;
    p1 = a2 * b1;
    return crs_t'(p0) - crs_t'(p1);
  endfunction

endpackage

// File: design/sti_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
module sti_divider #(
  parameter int SideWidth = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [sti_pkg::NumWidth-1:0]  num_i,
  input  logic [sti_pkg::SumWidth-1:0]  den_i,
  input  logic [SideWidth-1:0]          side_i,
  output logic                          valid_o,
  output logic [sti_pkg::QuoWidth-1:0]  quo_o,
  output logic [SideWidth-1:0]          side_o
);
  import sti_pkg::*;

  logic                val_q  [QuoWidth];
  logic [NumWidth-1:0] rem_q  [QuoWidth];
  logic [QuoWidth-1:0] quo_q  [QuoWidth];
  logic [SumWidth-1:0] den_q  [QuoWidth];
  logic [SideWidth-1:0] side_q [QuoWidth];

  for (genvar j = 0; j < QuoWidth; j++) begin : g_stage
    logic                 val_src;
    logic [NumWidth-1:0]  rem_src;
    logic [QuoWidth-1:0]  quo_src;
    logic [SumWidth-1:0]  den_src;
    logic [SideWidth-1:0] side_src;
    logic [NumWidth-1:0]  shifted;
    logic                 ge;

    if (j == 0) begin : g_first
      assign val_src  = valid_i;
      assign rem_src  = num_i;
      assign quo_src  = '0;
      assign den_src  = den_i;
      assign side_src = side_i;
    end else begin : g_next
      assign val_src  = val_q[j-1];
      assign rem_src  = rem_q[j-1];
      assign quo_src  = quo_q[j-1];
      assign den_src  = den_q[j-1];
      assign side_src = side_q[j-1];
    end

    assign shifted = NumWidth'(den_src) << (QuoWidth - 1 - j);
    assign ge      = rem_src >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[j] <= 1'b0;
      end else if (en_i) begin
        val_q[j] <= val_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? rem_src - shifted : rem_src;
        quo_q[j]  <= quo_src | (ge ? (QuoWidth'(1) << (QuoWidth - 1 - j)) : '0);
        den_q[j]  <= den_src;
        side_q[j] <= side_src;
      end
    end
  end

  assign valid_o = val_q[QuoWidth-1];
  assign quo_o   = quo_q[QuoWidth-1];
  assign side_o  = side_q[QuoWidth-1];

endmodule

// File: design/segment_triangle_intersect.sv
// Segment/triangle intersection pipeline: top level.
// Takes one transaction per clock while the output is not stalled and returns one result
// per transaction, in order, through seven stages for edge vectors, cross products,
// dot-product terms, sums, sign normalization, range tests and the point numerators, then one
// stage per quotient bit of the 17-bit divider, then the output register. When a result waits at
// the output the whole pipeline holds, so ready drops only while the output is stalled.
module segment_triangle_intersect (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sti_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sti_pkg::out_t out_data_o
);
  import sti_pkg::*;

  localparam int SideWidth = 3 * CoordWidth + 4;
  localparam int ResWidth  = DifWidth + 1;
  localparam logic signed [ResWidth-1:0] HiLim = ResWidth'((1 <<< (CoordWidth - 1)) - 1);
  localparam logic signed [ResWidth-1:0] LoLim = -HiLim - ResWidth'(1);

  logic en;
  logic out_valid_q;
  out_t out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  coord_t s_c [3];
  coord_t e_c [3];
  coord_t v0_c [3];
  coord_t v1_c [3];
  coord_t v2_c [3];

  assign s_c[0] = in_data_i.start_x;
  assign s_c[1] = in_data_i.start_y;
  assign s_c[2] = in_data_i.start_z;
  assign e_c[0] = in_data_i.end_x;
  assign e_c[1] = in_data_i.end_y;
  assign e_c[2] = in_data_i.end_z;
  for (genvar i = 0; i < 3; i++) begin : g_vtx
    assign v0_c[i] = in_data_i.vertex_a[i*CoordWidth +: CoordWidth];
    assign v1_c[i] = in_data_i.vertex_b[i*CoordWidth +: CoordWidth];
    assign v2_c[i] = in_data_i.vertex_c[i*CoordWidth +: CoordWidth];
  end

  logic   v_q [7];
  coord_t s1_q [3], s2_q [3], s3_q [3], s4_q [3], s5_q [3], s6_q [3], s7_q [3];
  dif_t   d1_q [3], d2_q [3], d3_q [3], d4_q [3], d5_q [3], d6_q [3];
  dif_t   e1_q [3], e2_q [3], m1_q [3], m2_q [3];
  logic   zl1_q, zl2_q, zl3_q, zl4_q, dz5_q, hit6_q, hit7_q;
  crs_t   n_q [3], p_q [3], q_q [3];
  prd_t   pd_q [3], pm_q [3], pb_q [3], pc_q [3];
  sum_t   det4_q, tn4_q, nb4_q, nc4_q;
  sum_t   det5_q, tn5_q, nb5_q, nc5_q;
  sum_t   det6_q, tn6_q, det7_q;
  logic   dneg7_q [3];
  logic [NumWidth-1:0] num7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 7; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < 7; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zl1_q <= (s_c[0] == e_c[0]) && (s_c[1] == e_c[1]) && (s_c[2] == e_c[2]);
      for (int i = 0; i < 3; i++) begin
        s1_q[i] <= s_c[i];
        d1_q[i] <= sub_ext(e_c[i], s_c[i]);
        e1_q[i] <= sub_ext(v1_c[i], v0_c[i]);
        e2_q[i] <= sub_ext(v2_c[i], v0_c[i]);
        m1_q[i] <= sub_ext(s_c[i], v0_c[i]);
      end

      zl2_q   <= zl1_q;
      n_q[0]  <= cross_el(e1_q[1], e2_q[2], e1_q[2], e2_q[1]);
      n_q[1]  <= cross_el(e1_q[2], e2_q[0], e1_q[0], e2_q[2]);
      n_q[2]  <= cross_el(e1_q[0], e2_q[1], e1_q[1], e2_q[0]);
      p_q[0]  <= cross_el(m1_q[1], e2_q[2], m1_q[2], e2_q[1]);
      p_q[1]  <= cross_el(m1_q[2], e2_q[0], m1_q[0], e2_q[2]);
      p_q[2]  <= cross_el(m1_q[0], e2_q[1], m1_q[1], e2_q[0]);
      q_q[0]  <= cross_el(e1_q[1], m1_q[2], e1_q[2], m1_q[1]);
      q_q[1]  <= cross_el(e1_q[2], m1_q[0], e1_q[0], m1_q[2]);
      q_q[2]  <= cross_el(e1_q[0], m1_q[1], e1_q[1], m1_q[0]);
      for (int i = 0; i < 3; i++) begin
        s2_q[i] <= s1_q[i];
        d2_q[i] <= d1_q[i];
        m2_q[i] <= m1_q[i];
      end

      zl3_q <= zl2_q;
      for (int i = 0; i < 3; i++) begin
        s3_q[i] <= s2_q[i];
        d3_q[i] <= d2_q[i];
        pd_q[i] <= d2_q[i] * n_q[i];
        pm_q[i] <= m2_q[i] * n_q[i];
        pb_q[i] <= d2_q[i] * p_q[i];
        pc_q[i] <= d2_q[i] * q_q[i];
      end

      zl4_q  <= zl3_q;
      det4_q <= sum_t'(pd_q[0]) + sum_t'(pd_q[1]) + sum_t'(pd_q[2]);
      tn4_q  <= -sum_t'(pm_q[0]) - sum_t'(pm_q[1]) - sum_t'(pm_q[2]);
      nb4_q  <= sum_t'(pb_q[0]) + sum_t'(pb_q[1]) + sum_t'(pb_q[2]);
      nc4_q  <= sum_t'(pc_q[0]) + sum_t'(pc_q[1]) + sum_t'(pc_q[2]);
      for (int i = 0; i < 3; i++) begin
        s4_q[i] <= s3_q[i];
        d4_q[i] <= d3_q[i];
      end

      dz5_q  <= zl4_q || (det4_q == '0);
      det5_q <= det4_q[SumWidth-1] ? -det4_q : det4_q;
      tn5_q  <= det4_q[SumWidth-1] ? -tn4_q  : tn4_q;
      nb5_q  <= det4_q[SumWidth-1] ? -nb4_q  : nb4_q;
      nc5_q  <= det4_q[SumWidth-1] ? -nc4_q  : nc4_q;
      for (int i = 0; i < 3; i++) begin
        s5_q[i] <= s4_q[i];
        d5_q[i] <= d4_q[i];
      end

      hit6_q <= !dz5_q
             && !tn5_q[SumWidth-1] && !(det5_q < tn5_q)
             && !nb5_q[SumWidth-1] && !(det5_q < nb5_q)
             && !nc5_q[SumWidth-1] && !(det5_q < nc5_q)
             && !((SumWidth+1)'(det5_q) < ((SumWidth+1)'(nb5_q) + (SumWidth+1)'(nc5_q)));
      det6_q <= det5_q;
      tn6_q  <= tn5_q;
      for (int i = 0; i < 3; i++) begin
        s6_q[i] <= s5_q[i];
        d6_q[i] <= d5_q[i];
      end

      hit7_q <= hit6_q;
      det7_q <= det6_q;
      for (int i = 0; i < 3; i++) begin
        s7_q[i]    <= s6_q[i];
        dneg7_q[i] <= d6_q[i][DifWidth-1];
        num7_q[i]  <= NumWidth'($unsigned(tn6_q))
                    * NumWidth'($unsigned(d6_q[i][DifWidth-1] ? -d6_q[i] : d6_q[i]));
      end
    end
  end

  logic                 dv_valid [3];
  logic [QuoWidth-1:0]  dv_quo   [3];
  logic [SideWidth-1:0] dv_side  [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    sti_divider #(
      .SideWidth(SideWidth)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(v_q[6]),
      .num_i  (num7_q[i]),
      .den_i  (det7_q),
      .side_i ({hit7_q, dneg7_q[i], 2'b00, s7_q[2], s7_q[1], s7_q[0]}),
      .valid_o(dv_valid[i]),
      .quo_o  (dv_quo[i]),
      .side_o (dv_side[i])
    );
  end

  logic   fin_valid;
  logic   fin_hit;
  coord_t pt [3];

  assign fin_valid = dv_valid[0] && dv_valid[1] && dv_valid[2];
  assign fin_hit   = dv_side[0][SideWidth-1];

  for (genvar i = 0; i < 3; i++) begin : g_pt
    logic signed [ResWidth-1:0] s_ext;
    logic signed [ResWidth-1:0] q_ext;
    logic signed [ResWidth-1:0] r;
    assign s_ext = ResWidth'($signed(dv_side[i][i*CoordWidth +: CoordWidth]));
    assign q_ext = $signed({1'b0, dv_quo[i]});
    assign r     = dv_side[i][SideWidth-2] ? s_ext - q_ext : s_ext + q_ext;
    assign pt[i] = !fin_hit ? '0 :
                   (r > HiLim) ? HiLim[CoordWidth-1:0] :
                   (r < LoLim) ? LoLim[CoordWidth-1:0] : r[CoordWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.hit     <= fin_hit;
      out_data_q.point_x <= pt[0];
      out_data_q.point_y <= pt[1];
      out_data_q.point_z <= pt[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/sti_checker.sv
// Port-level checker for the segment/triangle block and its bind.
module sti_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input sti_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sti_pkg::out_t out_data_o
);
  import sti_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("Waiting input transaction changed.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.point_x == '0 && out_data_o.point_y == '0 && out_data_o.point_z == '0)
    else $error("Result without a hit carries a nonzero point.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result transaction changed.");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("Input ready while the output is stalled.");

endmodule

bind segment_triangle_intersect sti_checker u_sti_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// File: tb/sv/segment_triangle_intersect_checker.sv
// Checker that predicts and compares the results of the segment/triangle block.
`timescale 1ns / 100ps

module segment_triangle_intersect_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  sti_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  sti_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o
);
  import sti_pkg::*;

  typedef logic signed [127:0] big_t;

  out_t crossings_q[$];

  function automatic out_t intersect_point(in_t tr);
    big_t  s[3], e[3], v0[3], v1[3], v2[3];
    big_t  d[3], e1[3], e2[3], m[3], n[3], p[3], q[3];
    big_t  det, tn, nb, nc, quo, mag, r;
    out_t  res;
    coord_t c;
    s[0] = big_t'(tr.start_x);
    s[1] = big_t'(tr.start_y);
    s[2] = big_t'(tr.start_z);
    e[0] = big_t'(tr.end_x);
    e[1] = big_t'(tr.end_y);
    e[2] = big_t'(tr.end_z);
    for (int i = 0; i < 3; i++) begin
      c = coord_t'(tr.vertex_a[i*CoordWidth +: CoordWidth]);
      v0[i] = big_t'(c);
      c = coord_t'(tr.vertex_b[i*CoordWidth +: CoordWidth]);
      v1[i] = big_t'(c);
      c = coord_t'(tr.vertex_c[i*CoordWidth +: CoordWidth]);
      v2[i] = big_t'(c);
    end
    res = '0;
    if (s[0] == e[0] && s[1] == e[1] && s[2] == e[2]) return res;
    for (int i = 0; i < 3; i++) begin
      d[i]  = e[i] - s[i];
      e1[i] = v1[i] - v0[i];
      e2[i] = v2[i] - v0[i];
      m[i]  = s[i] - v0[i];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    p[0] = m[1] * e2[2] - m[2] * e2[1];
    p[1] = m[2] * e2[0] - m[0] * e2[2];
    p[2] = m[0] * e2[1] - m[1] * e2[0];
    q[0] = e1[1] * m[2] - e1[2] * m[1];
    q[1] = e1[2] * m[0] - e1[0] * m[2];
    q[2] = e1[0] * m[1] - e1[1] * m[0];
    det = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    tn  = -(m[0] * n[0] + m[1] * n[1] + m[2] * n[2]);
    nb  = d[0] * p[0] + d[1] * p[1] + d[2] * p[2];
    nc  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    if (det == 0) return res;
    if (det < 0) begin
      det = -det;
      tn  = -tn;
      nb  = -nb;
      nc  = -nc;
    end
    if (tn < 0 || tn > det || nb < 0 || nb > det || nc < 0 || nc > det || nb + nc > det)
      return res;
    res.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      quo = (tn * mag) / det;
      r = s[i] + ((d[i] < 0) ? -quo : quo);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      c = coord_t'(r);
      case (i)
        0: res.point_x = c;
        1: res.point_y = c;
        default: res.point_z = c;
      endcase
    end
    return res;
  endfunction

  assign pending_o = crossings_q.size();

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) crossings_q.push_back(intersect_point(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (crossings_q.size() == 0) begin
          errors_o <= errors_o + 1;
          $display("%0t: unexpected result %h", $time, out_data_i);
        end else begin
          want = crossings_q.pop_front();
          if (want !== out_data_i) begin
            errors_o <= errors_o + 1;
            $display({"%0t: mismatch expected hit=%b x=%0d y=%0d z=%0d, ",
                      "actual hit=%b x=%0d y=%0d z=%0d"},
                     $time, want.hit, want.point_x, want.point_y, want.point_z,
                     out_data_i.hit, out_data_i.point_x, out_data_i.point_y,
                     out_data_i.point_z);
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/segment_triangle_intersect_test.sv
// Testbench top that drives the segment/triangle block and reports the verdict.
`timescale 1ns / 100ps

module segment_triangle_intersect_test;
  import sti_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   errors;
  int   pending;
  logic long_hold;
  logic calm;

  segment_triangle_intersect i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  segment_triangle_intersect_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] pack_vertex(int x, int y, int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic in_t make_item(int sx, int sy, int sz, int ex, int ey, int ez,
                                    logic [47:0] va, logic [47:0] vb, logic [47:0] vc);
    in_t tr;
    tr.start_x = coord_t'(sx);
    tr.start_y = coord_t'(sy);
    tr.start_z = coord_t'(sz);
    tr.end_x = coord_t'(ex);
    tr.end_y = coord_t'(ey);
    tr.end_z = coord_t'(ez);
    tr.vertex_a = va;
    tr.vertex_b = vb;
    tr.vertex_c = vc;
    return tr;
  endfunction

  function automatic in_t crossing_item();
    int v[3][3];
    int b, c, px, py, pz, dx, dy, dz, u, w, lim;
    lim = ($urandom_range(0, 3) == 0) ? 32000 : 8000;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) v[i][j] = $urandom_range(0, 2 * lim) - lim;
    b = $urandom_range(0, 16);
    c = $urandom_range(0, 16 - b);
    px = v[0][0] + (b * (v[1][0] - v[0][0]) + c * (v[2][0] - v[0][0])) / 16;
    py = v[0][1] + (b * (v[1][1] - v[0][1]) + c * (v[2][1] - v[0][1])) / 16;
    pz = v[0][2] + (b * (v[1][2] - v[0][2]) + c * (v[2][2] - v[0][2])) / 16;
    dx = $urandom_range(0, 8000) - 4000;
    dy = $urandom_range(0, 8000) - 4000;
    dz = $urandom_range(0, 8000) - 4000;
    u = $urandom_range(0, 8);
    w = $urandom_range(0, 8);
    if ($urandom_range(0, 15) == 0) w = -w;
    return make_item(px + dx * u / 8, py + dy * u / 8, pz + dz * u / 8,
                     px - dx * w / 8, py - dy * w / 8, pz - dz * w / 8,
                     pack_vertex(v[0][0], v[0][1], v[0][2]),
                     pack_vertex(v[1][0], v[1][1], v[1][2]),
                     pack_vertex(v[2][0], v[2][1], v[2][2]));
  endfunction

  function automatic in_t noise_item();
    in_t tr;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    tr = raw[$bits(in_t)-1:0];
    if ($urandom_range(0, 7) == 0) begin
      tr.end_x = tr.start_x;
      tr.end_y = tr.start_y;
      tr.end_z = tr.start_z;
    end
    return tr;
  endfunction

  task automatic send(in_t tr);
    int g;
    in_data <= tr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    g = idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  initial begin
    int hold;
    logic held;
    out_ready = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 200) begin
          @(negedge clk);
          hold++;
        end
        held = 1'b1;
      end
      if (calm || $urandom_range(0, 9) < 6) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2))
          @(negedge clk);
      end
    end
  end

  initial begin
    logic [47:0] va, vb, vc;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    long_hold = 1'b0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    va = pack_vertex(0, 0, 0);
    vb = pack_vertex(256, 0, 0);
    vc = pack_vertex(0, 256, 0);
    send(make_item(64, 64, 256, 64, 64, -256, va, vb, vc));
    send(make_item(64, 64, -256, 64, 64, 256, va, vb, vc));
    send(make_item(128, 128, 256, 128, 128, -256, va, vb, vc));
    send(make_item(0, 0, 256, 0, 0, -256, va, vb, vc));
    send(make_item(256, 0, 256, 256, 0, -256, va, vb, vc));
    send(make_item(64, 64, 0, 64, 64, -256, va, vb, vc));
    send(make_item(64, 64, 256, 64, 64, 0, va, vb, vc));
    send(make_item(64, 64, 256, 64, 64, 1, va, vb, vc));
    send(make_item(200, 200, 256, 200, 200, -256, va, vb, vc));
    send(make_item(64, 64, 0, 64, 64, 0, va, vb, vc));
    send(make_item(64, 64, 256, 128, 64, 256, va, vb, vc));
    send(make_item(0, 0, 256, 0, 0, -256, va, pack_vertex(256, 256, 0),
                   pack_vertex(512, 512, 0)));
    send(make_item(-32768, -32768, -32768, 32767, 32767, 32767,
                   pack_vertex(-32768, 32767, 0), pack_vertex(32767, -32768, 0),
                   pack_vertex(32767, 32767, -32768)));
    send(make_item(32767, 32767, 32767, -32768, -32768, -32768,
                   pack_vertex(32767, -32768, 0), pack_vertex(-32768, 32767, 0),
                   pack_vertex(-32768, -32768, 32767)));
    send(make_item(-32768, -32768, 32767, -32768, -32768, -32768,
                   pack_vertex(-32768, -32768, 0), pack_vertex(32767, -32768, 0),
                   pack_vertex(-32768, 32767, 0)));
    send(make_item(32767, 0, 0, -32768, 0, 0, pack_vertex(0, -32768, -32768),
                   pack_vertex(0, 32767, -32768), pack_vertex(0, -32768, 32767)));
    send(make_item(5, -7, 3, -11, 9, -2, pack_vertex(-300, -300, 1),
                   pack_vertex(300, -300, 0), pack_vertex(0, 300, -1)));
    send(make_item(-1, -1, -1, -1, -1, -1, '1, '1, '1));
    send(make_item(0, 0, 0, 1, 0, 0, '0, '0, '0));
    for (int k = 0; k < 1900; k++) begin
      if (k % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      if (k == 400) begin
        calm = 1'b1;
        long_hold = 1'b1;
      end
      if (k == 1000) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      send(($urandom_range(0, 9) < 7) ? crossing_item() : noise_item());
    end
    in_valid <= 1'b0;
    calm = 1'b1;
    waited = 0;
    while (pending != 0 && waited < 100_000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
